// ----- rtl/wmm_pkg.sv -----
package wmm_pkg;

  typedef enum logic [1:0] {
    OP_MASK_APPEND = 2'd0,
    OP_SUBJ_APPEND = 2'd1,
    OP_RUN         = 2'd2,
    OP_MASK_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_NO_MATCH  = 2'd0,
    RES_MATCH     = 2'd1,
    RES_BUF_OVF   = 2'd2,
    RES_STACK_OVF = 2'd3
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_FETCH, ST_DECIDE, ST_NUM_RD, ST_NUM_EV, ST_STAR,
    ST_DEAD_RD, ST_DEAD_EV, ST_BACK, ST_BK_LD, ST_BK_X, ST_RP_RD, ST_RP_EV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DSEL_PM    = 2'd0,
    DSEL_STACK = 2'd1,
    DSEL_FRAME = 2'd2
  } dsel_t;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_STAR  = 16'h002A;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_ONE   = 16'h0031;
  localparam logic [15:0] CH_TWO   = 16'h0032;
  localparam logic [15:0] CH_FOUR  = 16'h0034;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_QMARK = 16'h003F;
  localparam logic [15:0] CH_BSL   = 16'h005C;

  typedef struct packed {
    logic  load;
    logic  start;
    logic  clr;
    logic  fetch;
    logic  step_char;
    logic  step_colon;
    logic  num_init;
    logic  num_rd;
    logic  num_eval;
    logic  push;
    logic  back_load;
    logic  back_pop;
    logic  back_adv;
    logic  rep_eval;
    logic  stk_top;
    dsel_t dsel;
    logic  set_res;
    res_t  res;
    logic  finish;
  } wmm_cmd_t;

  typedef struct packed {
    logic overflow;
    logic clr_last;
    logic fetch_last;
    logic m0_zero;
    logic s0_zero;
    logic is_star;
    logic tok34;
    logic colon_ok;
    logic chr_ok;
    logic num_fin;
    logic num_ok;
    logic stack_full;
    logic star_end;
    logic dead_fwd;
    logic dead_adv;
    logic depth_zero;
    logic cur_at_end;
    logic rep_end;
    logic out_free;
  } wmm_sts_t;

  function automatic logic is_ws(input logic [15:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic char_ok(input logic [15:0] m, input logic [15:0] s);
    return (m == s) || ((m == CH_QMARK) && (s != '0)) || ((m == CH_SPACE) && is_ws(s));
  endfunction

endpackage

// ----- rtl/wildcard_mask_match_capture.sv -----
// Load and mask-clear items give no result.
// A run item, unless a store has overflowed, clears the dead-state rows, then steps
// forward through the mask RAM and backtracks; on a match it reads the frames out.
// The result goes into the output register; the backtracking search decides how long a run takes.
// Reset clears the counts, the overflow flag and the frame stack; the character stores
// hold no valid data until written.
module wildcard_mask_match_capture import wmm_pkg::*; #(
  parameter int MASK_LEN     = 64,
  parameter int SUBJECT_LEN  = 256,
  parameter int STACK_FRAMES = 20,
  parameter int CAPTURE_MAX  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // ch
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, capture_present, file1_start, file1_len, file2_start, file2_len,
  // line_start, line_len, col_start, col_len, zero padding
  output logic [79:0] m_tdata
);

  wmm_cmd_t cmd;
  wmm_sts_t sts;
  op_t      op;

  assign op = op_t'(s_tuser);

  wmm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .op(op), .s_tready(s_tready),
    .sts(sts), .cmd(cmd)
  );

  wmm_datapath #(
    .MASK_LEN(MASK_LEN), .SUBJECT_LEN(SUBJECT_LEN),
    .STACK_FRAMES(STACK_FRAMES), .CAPTURE_MAX(CAPTURE_MAX)
  ) u_datapath (
    .clk(clk), .rst(rst), .op(op), .ch(s_tdata), .cmd(cmd), .sts(sts),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata)
  );

endmodule

// ----- rtl/wmm_ram.sv -----
module wmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/wmm_datapath.sv -----
module wmm_datapath import wmm_pkg::*; #(
  parameter int MASK_LEN     = 64,
  parameter int SUBJECT_LEN  = 256,
  parameter int STACK_FRAMES = 20,
  parameter int CAPTURE_MAX  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  logic [15:0] ch,
  input  wmm_cmd_t    cmd,
  output wmm_sts_t    sts,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [79:0] m_tdata
);

  localparam int MA = $clog2(MASK_LEN);
  localparam int PW = $clog2(MASK_LEN + 1);
  localparam int MW = $clog2(MASK_LEN + 4);
  localparam int SA = $clog2(SUBJECT_LEN);
  localparam int XW = $clog2(SUBJECT_LEN + 1);
  localparam int SW = $clog2(SUBJECT_LEN + 2);
  localparam int RW = SUBJECT_LEN + 1;
  localparam int DW = $clog2(STACK_FRAMES + 1);
  localparam int KA = (STACK_FRAMES > 1) ? $clog2(STACK_FRAMES) : 1;
  localparam int FW = PW + 2 * XW + 3;
  localparam int CW = $clog2(CAPTURE_MAX + 1);
  localparam int LW0 = (XW > CW) ? XW : CW;
  localparam int LW = (LW0 > 9) ? LW0 : 9;
  localparam int BW = (XW > 9) ? XW : 9;

  logic [PW-1:0] mask_count;
  logic [XW-1:0] subject_count;
  logic          overflow;
  logic [MW-1:0] pm;
  logic [XW-1:0] ps;
  logic [2:0]    fcnt;
  logic          m_ok, s_ok;
  logic [15:0]   mc [4];
  logic [15:0]   sc [2];
  logic [XW-1:0] q;
  logic          nphase;
  logic [DW-1:0] depth;
  logic [DW-1:0] ri;
  logic [PW-1:0] clr_idx;
  logic [PW-1:0] f_mask;
  logic [XW-1:0] f_begin;
  logic [XW-1:0] f_cur;
  logic [2:0]    f_tok;
  res_t          res;
  logic [3:0]    cap_present;
  logic [8:0]    cap_start [4];
  logic [8:0]    cap_len [4];
  logic          out_valid;
  logic [77:0]   out_data;

  logic [MW-1:0] maddr;
  logic [SW-1:0] saddr;
  logic [15:0]   mrd, srd, mch, sch;
  logic          mask_we, subj_we;
  logic [RW-1:0] dead_rd, dead_wdata, range_bits;
  logic [PW-1:0] dead_raddr, dead_waddr;
  logic          dead_we;
  logic [FW-1:0] stk_rd, stk_wdata;
  logic [KA-1:0] stk_waddr, stk_raddr;
  logic          stk_we;
  logic [DW-1:0] dm1;
  logic [1:0]    slot;
  logic [2:0]    tok;
  logic [MW-1:0] pm_new;
  logic [XW-1:0] cur_inc;
  logic          num_fin, num_ok, num_adv, num_sign;
  logic [2:0]    e_tok;
  logic [XW-1:0] e_begin, e_cur;
  logic [LW-1:0] e_len, e_len_cap;
  logic [BW-1:0] e_begin_w;
  logic [1:0]    e_idx;

  assign mch = m_ok ? mrd : '0;
  assign sch = s_ok ? srd : '0;
  assign maddr = pm + MW'(fcnt);
  assign saddr = cmd.num_rd ? SW'(q) : (SW'(ps) + SW'(fcnt));
  assign slot = fcnt[1:0] - 2'd1;
  assign dm1 = depth - DW'(1);
  assign tok = ((mc[1] >= CH_ONE) && (mc[1] <= CH_FOUR)) ? mc[1][2:0] : 3'd0;
  assign pm_new = (mc[1] != '0) ? pm + MW'(2) : pm + MW'(1);
  assign cur_inc = f_cur + XW'(1);

  assign mask_we = cmd.load && (op == OP_MASK_APPEND) && (ch != '0)
                   && (mask_count < PW'(MASK_LEN));
  assign subj_we = cmd.load && (op == OP_SUBJ_APPEND) && (ch != '0)
                   && (subject_count < XW'(SUBJECT_LEN));

  wmm_ram #(.WIDTH(16), .DEPTH(MASK_LEN)) u_mask_ram (
    .clk(clk), .we(mask_we), .waddr(mask_count[MA-1:0]), .wdata(ch),
    .raddr(maddr[MA-1:0]), .rdata(mrd)
  );

  wmm_ram #(.WIDTH(16), .DEPTH(SUBJECT_LEN)) u_subj_ram (
    .clk(clk), .we(subj_we), .waddr(subject_count[SA-1:0]), .wdata(ch),
    .raddr(saddr[SA-1:0]), .rdata(srd)
  );

  // Dead-state rows: one row per mask position, one bit per subject position.
  always_comb begin
    for (int x = 0; x < RW; x++) begin
      range_bits[x] = (XW'(x) >= f_begin) && (XW'(x) <= subject_count);
    end
  end

  always_comb begin
    unique case (cmd.dsel)
      DSEL_STACK: dead_raddr = stk_rd[FW-1 -: PW];
      DSEL_FRAME: dead_raddr = f_mask;
      default:    dead_raddr = pm[PW-1:0];
    endcase
  end

  assign dead_we    = cmd.clr || cmd.back_pop;
  assign dead_waddr = cmd.clr ? clr_idx : f_mask;
  assign dead_wdata = cmd.clr ? '0 : (dead_rd | range_bits);

  wmm_ram #(.WIDTH(RW), .DEPTH(MASK_LEN + 1)) u_dead_ram (
    .clk(clk), .we(dead_we), .waddr(dead_waddr), .wdata(dead_wdata),
    .raddr(dead_raddr), .rdata(dead_rd)
  );

  // Stack frame: mask position, capture begin, current end, token.
  assign stk_we    = cmd.push || cmd.back_adv;
  assign stk_waddr = cmd.push ? depth[KA-1:0] : dm1[KA-1:0];
  assign stk_raddr = cmd.stk_top ? dm1[KA-1:0] : ri[KA-1:0];
  assign stk_wdata = cmd.push
                   ? {pm_new[PW-1:0], ps, (sts.star_end ? subject_count : ps), tok}
                   : {f_mask, f_begin, cur_inc, f_tok};

  wmm_ram #(.WIDTH(FW), .DEPTH(STACK_FRAMES)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  // Signed-number scan: leading whitespace, optional sign, then a digit.
  always_comb begin
    num_fin  = 1'b0;
    num_ok   = 1'b0;
    num_adv  = 1'b0;
    num_sign = 1'b0;
    if (nphase) begin
      num_fin = 1'b1;
      num_ok  = (sch >= CH_ZERO) && (sch <= CH_NINE);
    end else if (is_ws(sch)) begin
      num_adv = 1'b1;
    end else if (sch == '0) begin
      num_fin = 1'b1;
    end else if ((sch == CH_MINUS) || (sch == CH_PLUS)) begin
      num_adv  = 1'b1;
      num_sign = 1'b1;
    end else begin
      num_fin = 1'b1;
      num_ok  = (sch >= CH_ZERO) && (sch <= CH_NINE);
    end
  end

  assign e_tok     = stk_rd[2:0];
  assign e_cur     = stk_rd[3 +: XW];
  assign e_begin   = stk_rd[3 + XW +: XW];
  assign e_len     = LW'(e_cur - e_begin);
  assign e_len_cap = (e_len > LW'(CAPTURE_MAX)) ? LW'(CAPTURE_MAX) : e_len;
  assign e_begin_w = BW'(e_begin);
  assign e_idx     = e_tok[1:0] - 2'd1;

  always_comb begin
    sts.overflow   = overflow;
    sts.clr_last   = (clr_idx == mask_count);
    sts.fetch_last = (fcnt == 3'd4);
    sts.m0_zero    = (mc[0] == '0);
    sts.s0_zero    = (sc[0] == '0);
    sts.is_star    = (mc[0] == CH_STAR);
    sts.tok34      = (tok == 3'd3) || (tok == 3'd4);
    sts.colon_ok   = (mc[0] == CH_COLON) && (mc[1] == CH_BSL) && (mc[2] == CH_STAR)
                     && (mc[3] == CH_TWO) && (sc[0] == CH_COLON)
                     && ((sc[1] == CH_BSL) || (sc[1] == CH_SLASH));
    sts.chr_ok     = char_ok(mc[0], sc[0]);
    sts.num_fin    = num_fin;
    sts.num_ok     = num_ok;
    sts.stack_full = (depth >= DW'(STACK_FRAMES));
    sts.star_end   = (mc[1] == '0) || (mc[2] == '0);
    sts.dead_fwd   = dead_rd[ps];
    sts.dead_adv   = dead_rd[cur_inc];
    sts.depth_zero = (depth == '0);
    sts.cur_at_end = (f_cur >= subject_count);
    sts.rep_end    = (ri == depth);
    sts.out_free   = !out_valid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_count    <= '0;
      subject_count <= '0;
      overflow      <= 1'b0;
      depth         <= '0;
      fcnt          <= '0;
      out_valid     <= 1'b0;
    end else begin
      fcnt <= cmd.fetch ? fcnt + 3'd1 : 3'd0;
      if (cmd.load) begin
        unique case (op)
          OP_MASK_APPEND: begin
            if (ch != '0) begin
              if (mask_count < PW'(MASK_LEN)) mask_count <= mask_count + PW'(1);
              else overflow <= 1'b1;
            end
          end
          OP_SUBJ_APPEND: begin
            if (ch != '0) begin
              if (subject_count < XW'(SUBJECT_LEN)) subject_count <= subject_count + XW'(1);
              else overflow <= 1'b1;
            end
          end
          OP_MASK_CLEAR: mask_count <= '0;
          default: ;
        endcase
      end
      if (cmd.start) depth <= '0;
      else if (cmd.push) depth <= depth + DW'(1);
      else if (cmd.back_pop) depth <= dm1;
      if (cmd.finish) begin
        subject_count <= '0;
        overflow      <= 1'b0;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_ok <= maddr < MW'(mask_count);
    s_ok <= saddr < SW'(subject_count);
    if (cmd.fetch && (fcnt != 3'd0)) begin
      mc[slot] <= mch;
      if (slot < 2'd2) sc[slot[0]] <= sch;
    end
    if (cmd.start) begin
      pm          <= '0;
      ps          <= '0;
      clr_idx     <= '0;
      ri          <= '0;
      res         <= RES_NO_MATCH;
      cap_present <= '0;
      for (int i = 0; i < 4; i++) begin
        cap_start[i] <= '0;
        cap_len[i]   <= '0;
      end
    end
    if (cmd.clr) clr_idx <= clr_idx + PW'(1);
    if (cmd.step_char) begin
      pm <= pm + MW'(1);
      ps <= ps + XW'(1);
    end
    if (cmd.step_colon) begin
      pm <= pm + MW'(2);
      ps <= ps + XW'(2);
    end
    if (cmd.num_init) begin
      q      <= ps;
      nphase <= 1'b0;
    end
    if (cmd.num_eval && num_adv) begin
      q <= q + XW'(1);
      if (num_sign) nphase <= 1'b1;
    end
    if (cmd.push) pm <= pm_new;
    if (cmd.back_load) begin
      f_mask  <= stk_rd[FW-1 -: PW];
      f_begin <= e_begin;
      f_cur   <= e_cur;
      f_tok   <= e_tok;
    end
    if (cmd.back_adv) begin
      f_cur <= cur_inc;
      pm    <= MW'(f_mask);
      ps    <= cur_inc;
    end
    if (cmd.set_res) res <= cmd.res;
    if (cmd.rep_eval) begin
      ri <= ri + DW'(1);
      // Later frames overwrite earlier ones, so the rightmost star wins.
      if (e_tok != 3'd0) begin
        cap_present[e_idx] <= 1'b1;
        cap_start[e_idx]   <= e_begin_w[8:0];
        cap_len[e_idx]     <= e_len_cap[8:0];
      end
    end
    if (cmd.finish) begin
      out_data <= {cap_len[3], cap_start[3], cap_len[2], cap_start[2],
                   cap_len[1], cap_start[1], cap_len[0], cap_start[0],
                   cap_present, res};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_data};

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> depth < DW'(STACK_FRAMES))
    else $error("push into a full frame stack");

  a_adv_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.back_adv |-> f_cur < subject_count)
    else $error("star advanced past the end of the subject");

  a_fetch_pm: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> pm <= MW'(mask_count))
    else $error("mask position beyond loaded mask");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> out_valid)
    else $error("result dropped before it was taken");

endmodule

// ----- rtl/wmm_ctrl.sv -----
module wmm_ctrl import wmm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  op_t      op,
  output logic     s_tready,
  input  wmm_sts_t sts,
  output wmm_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && (op == OP_RUN)) state_next = sts.overflow ? ST_DONE : ST_CLEAR;
      end
      ST_CLEAR:   if (sts.clr_last) state_next = ST_FETCH;
      ST_FETCH:   if (sts.fetch_last) state_next = ST_DECIDE;
      ST_DECIDE: begin
        priority if (sts.m0_zero) state_next = sts.s0_zero ? ST_RP_RD : ST_BACK;
        else if (sts.is_star)     state_next = sts.tok34 ? ST_NUM_RD : ST_STAR;
        else if (sts.colon_ok)    state_next = ST_FETCH;
        else if (sts.chr_ok)      state_next = ST_FETCH;
        else                      state_next = ST_BACK;
      end
      ST_NUM_RD:  state_next = ST_NUM_EV;
      ST_NUM_EV: begin
        if (sts.num_fin) state_next = sts.num_ok ? ST_STAR : ST_BACK;
        else             state_next = ST_NUM_RD;
      end
      ST_STAR: begin
        priority if (sts.stack_full) state_next = ST_DONE;
        else if (sts.star_end)       state_next = ST_RP_RD;
        else                         state_next = ST_DEAD_RD;
      end
      ST_DEAD_RD: state_next = ST_DEAD_EV;
      ST_DEAD_EV: state_next = sts.dead_fwd ? ST_BACK : ST_FETCH;
      ST_BACK:    state_next = sts.depth_zero ? ST_DONE : ST_BK_LD;
      ST_BK_LD:   state_next = ST_BK_X;
      ST_BK_X: begin
        priority if (sts.cur_at_end) state_next = ST_BACK;
        else if (sts.dead_adv)       state_next = ST_BK_X;
        else                         state_next = ST_FETCH;
      end
      ST_RP_RD:   state_next = sts.rep_end ? ST_DONE : ST_RP_EV;
      ST_RP_EV:   state_next = ST_RP_RD;
      ST_DONE:    if (sts.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.dsel = DSEL_PM;
    cmd.res  = RES_NO_MATCH;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (op == OP_RUN) begin
            cmd.start = 1'b1;
            if (sts.overflow) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_BUF_OVF;
            end
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_CLEAR: cmd.clr = 1'b1;
      ST_FETCH: cmd.fetch = 1'b1;
      ST_DECIDE: begin
        priority if (sts.m0_zero) begin
          cmd.set_res = sts.s0_zero;
          cmd.res     = RES_MATCH;
        end else if (sts.is_star) begin
          cmd.num_init = sts.tok34;
        end else if (sts.colon_ok) begin
          cmd.step_colon = 1'b1;
        end else if (sts.chr_ok) begin
          cmd.step_char = 1'b1;
        end else begin
          cmd.set_res = 1'b0;
        end
      end
      ST_NUM_RD: cmd.num_rd = 1'b1;
      ST_NUM_EV: cmd.num_eval = 1'b1;
      ST_STAR: begin
        if (sts.stack_full) begin
          cmd.set_res = 1'b1;
          cmd.res     = RES_STACK_OVF;
        end else begin
          cmd.push    = 1'b1;
          cmd.set_res = sts.star_end;
          cmd.res     = RES_MATCH;
        end
      end
      ST_DEAD_RD: cmd.dsel = DSEL_PM;
      ST_DEAD_EV: cmd.dsel = DSEL_PM;
      ST_BACK:    cmd.stk_top = 1'b1;
      ST_BK_LD: begin
        cmd.back_load = 1'b1;
        cmd.dsel      = DSEL_STACK;
      end
      ST_BK_X: begin
        cmd.dsel = DSEL_FRAME;
        if (sts.cur_at_end) cmd.back_pop = 1'b1;
        else                cmd.back_adv = 1'b1;
      end
      ST_RP_RD: cmd.stk_top = 1'b0;
      ST_RP_EV: cmd.rep_eval = 1'b1;
      ST_DONE:  cmd.finish = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- dv/tb_wildcard_mask_match_capture.sv -----
module tb_wildcard_mask_match_capture;
  import wmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MASK_DEPTH  = 64;
  localparam int SUBJ_DEPTH  = 256;
  localparam int FRAME_LIMIT = 20;
  localparam int SPAN_CAP    = 256;

  typedef struct {
    op_t         op;
    logic [15:0] ch;
  } text_item_t;

  typedef struct {
    res_t       status;
    logic [3:0] present;
    logic [8:0] span_start [4];
    logic [8:0] span_len [4];
  } match_report_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;

  wildcard_mask_match_capture u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  text_item_t    pending_items[$];
  match_report_t expected_reports[$];
  int            n_queued;
  int            n_accepted;
  int            n_errors;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_go;
  int            hold_left;

  // Private copy of the matcher state.
  logic [15:0] pat_chars [MASK_DEPTH];
  int          pat_count;
  logic [15:0] line_chars [SUBJ_DEPTH];
  int          line_count;
  bit          overrun;
  int          frm_pat [FRAME_LIMIT];
  int          frm_begin [FRAME_LIMIT];
  int          frm_cur [FRAME_LIMIT];
  int          frm_tok [FRAME_LIMIT];
  int          frm_depth;
  bit          failed_at [MASK_DEPTH+1][SUBJ_DEPTH+1];

  function automatic int pat_at(int i);
    return i < pat_count ? int'(pat_chars[i]) : 0;
  endfunction

  function automatic int line_at(int i);
    return i < line_count ? int'(line_chars[i]) : 0;
  endfunction

  function automatic bit blank_char(int c);
    return c == 32 || c == 9 || c == 13 || c == 10;
  endfunction

  function automatic bit signed_number_at(int p);
    if (line_at(p) == 0) return 0;
    while (blank_char(line_at(p))) p++;
    if (line_at(p) == 0) return 0;
    if (line_at(p) == int'(CH_MINUS) || line_at(p) == int'(CH_PLUS)) p++;
    return line_at(p) >= int'(CH_ZERO) && line_at(p) <= int'(CH_NINE);
  endfunction

  function automatic void push_frame(int pm, int b, int c, int tok);
    frm_pat[frm_depth] = pm;
    frm_begin[frm_depth] = b;
    frm_cur[frm_depth] = c;
    frm_tok[frm_depth] = tok;
    frm_depth++;
  endfunction

  function automatic res_t search_match();
    int pm, ps, c, t, tok, k, x;
    bit fwd;
    pm = 0;
    ps = 0;
    fwd = 1;
    frm_depth = 0;
    foreach (failed_at[i, j]) failed_at[i][j] = 0;
    forever begin
      while (fwd) begin
        c = pat_at(pm);
        if (c == 0) begin
          if (line_at(ps) == 0) return RES_MATCH;
          fwd = 0;
          break;
        end
        if (c == int'(CH_STAR)) begin
          t = pat_at(pm + 1);
          tok = (t >= int'(CH_ONE) && t <= int'(CH_FOUR)) ? t - int'(CH_ZERO) : 0;
          if ((tok == 3 || tok == 4) && !signed_number_at(ps)) begin
            fwd = 0;
            break;
          end
          pm = (t != 0) ? pm + 2 : pm + 1;
          if (frm_depth >= FRAME_LIMIT) return RES_STACK_OVF;
          if (pat_at(pm) == 0) begin
            push_frame(pm, ps, line_count, tok);
            return RES_MATCH;
          end
          push_frame(pm, ps, ps, tok);
          if (failed_at[pm][ps]) fwd = 0;
          continue;
        end
        if (c == int'(CH_COLON) && pat_at(pm + 1) == int'(CH_BSL) &&
            pat_at(pm + 2) == int'(CH_STAR) && pat_at(pm + 3) == int'(CH_TWO) &&
            line_at(ps) == int'(CH_COLON) &&
            (line_at(ps + 1) == int'(CH_BSL) || line_at(ps + 1) == int'(CH_SLASH))) begin
          pm += 2;
          ps += 2;
          continue;
        end
        if (!(c == line_at(ps) || (c == int'(CH_QMARK) && line_at(ps) != 0) ||
              (c == int'(CH_SPACE) && blank_char(line_at(ps))))) begin
          fwd = 0;
          break;
        end
        pm++;
        ps++;
      end
      while (!fwd && frm_depth > 0) begin
        k = frm_depth - 1;
        if (frm_cur[k] >= line_count) begin
          for (x = frm_begin[k]; x <= line_count; x++) failed_at[frm_pat[k]][x] = 1;
          frm_depth--;
          continue;
        end
        frm_cur[k]++;
        if (failed_at[frm_pat[k]][frm_cur[k]]) continue;
        pm = frm_pat[k];
        ps = frm_cur[k];
        fwd = 1;
      end
      if (!fwd) return RES_NO_MATCH;
    end
  endfunction

  function automatic void predict_item(text_item_t it);
    match_report_t r;
    int len;
    case (it.op)
      OP_MASK_APPEND: begin
        if (it.ch != 0) begin
          if (pat_count < MASK_DEPTH) begin
            pat_chars[pat_count] = it.ch;
            pat_count++;
          end else begin
            overrun = 1;
          end
        end
      end
      OP_SUBJ_APPEND: begin
        if (it.ch != 0) begin
          if (line_count < SUBJ_DEPTH) begin
            line_chars[line_count] = it.ch;
            line_count++;
          end else begin
            overrun = 1;
          end
        end
      end
      OP_MASK_CLEAR: pat_count = 0;
      default: begin
        r.present = 0;
        for (int i = 0; i < 4; i++) begin
          r.span_start[i] = 0;
          r.span_len[i] = 0;
        end
        r.status = overrun ? RES_BUF_OVF : search_match();
        if (r.status == RES_MATCH) begin
          for (int i = 0; i < frm_depth; i++) begin
            if (frm_tok[i] >= 1 && frm_tok[i] <= 4) begin
              len = frm_cur[i] - frm_begin[i];
              if (len > SPAN_CAP) len = SPAN_CAP;
              r.present[frm_tok[i]-1] = 1'b1;
              r.span_start[frm_tok[i]-1] = frm_begin[i][8:0];
              r.span_len[frm_tok[i]-1] = len[8:0];
            end
          end
        end
        line_count = 0;
        overrun = 0;
        frm_depth = 0;
        expected_reports.push_back(r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    text_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.op = op_t'(s_tuser);
        it.ch = s_tdata;
        predict_item(it);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.ch;
          s_tuser <= it.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go && hold_left == 0) hold_left <= 400;
    else if (hold_left > 1) hold_left <= hold_left - 1;
  end

  function automatic void check_field(string name, int expv, int act);
    if (expv != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, act);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    match_report_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result with no expectation waiting: %h", m_tdata);
          n_errors++;
        end else begin
          e = expected_reports.pop_front();
          check_field("status", e.status, m_tdata[1:0]);
          check_field("capture_present", e.present, m_tdata[5:2]);
          check_field("file1_start", e.span_start[0], m_tdata[14:6]);
          check_field("file1_len", e.span_len[0], m_tdata[23:15]);
          check_field("file2_start", e.span_start[1], m_tdata[32:24]);
          check_field("file2_len", e.span_len[1], m_tdata[41:33]);
          check_field("line_start", e.span_start[2], m_tdata[50:42]);
          check_field("line_len", e.span_len[2], m_tdata[59:51]);
          check_field("col_start", e.span_start[3], m_tdata[68:60]);
          check_field("col_len", e.span_len[3], m_tdata[77:69]);
        end
      end
      m_tready <= (hold_left <= 1) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_item(op_t op, logic [15:0] ch);
    text_item_t it;
    it.op = op;
    it.ch = ch;
    pending_items.push_back(it);
    n_queued++;
  endtask

  function automatic logic [15:0] any_char();
    case ($urandom_range(7))
      0: return 16'($urandom_range(1, 65535));
      1: return CH_COLON;
      2: return CH_BSL;
      3: return CH_SLASH;
      4: return 16'(16'h0030 + $urandom_range(9));
      5: return CH_SPACE;
      default: return 16'(16'h0061 + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [15:0] blank_pick();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Builds a mask and, most of the time, a subject line that the mask should accept.
  task automatic queue_pair(int max_run);
    logic [15:0] pat[$];
    logic [15:0] line[$];
    int ntok, t, n;
    ntok = $urandom_range(1, 8);
    for (int i = 0; i < ntok; i++) begin
      case ($urandom_range(5))
        0, 1: begin
          t = 16'h0061 + $urandom_range(3);
          pat.push_back(16'(t));
          line.push_back(16'(t));
        end
        2: begin
          pat.push_back(CH_QMARK);
          line.push_back(any_char());
        end
        3: begin
          pat.push_back(CH_SPACE);
          line.push_back(blank_pick());
        end
        4: begin
          pat.push_back(CH_STAR);
          t = $urandom_range(5);
          if (t < 4) pat.push_back(16'(CH_ONE + t));
          else if (t == 4) pat.push_back(16'(16'h0061 + $urandom_range(3)));
          n = $urandom_range(max_run);
          for (int j = 0; j < n; j++) line.push_back(any_char());
          if (t == 2 || t == 3) begin
            if ($urandom_range(1)) line.push_back(blank_pick());
            if ($urandom_range(1)) line.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            line.push_back(16'(16'h0030 + $urandom_range(9)));
          end
        end
        default: begin
          pat.push_back(CH_COLON);
          pat.push_back(CH_BSL);
          pat.push_back(CH_STAR);
          pat.push_back(CH_TWO);
          line.push_back(CH_COLON);
          line.push_back($urandom_range(1) ? CH_BSL : CH_SLASH);
          n = $urandom_range(max_run);
          for (int j = 0; j < n; j++) line.push_back(any_char());
        end
      endcase
    end
    // A quarter of the lines are damaged so that the search must backtrack or fail.
    if (line.size() > 0 && $urandom_range(3) == 0) begin
      n = $urandom_range(line.size() - 1);
      if ($urandom_range(1)) line[n] = any_char();
      else line.delete(n);
    end
    queue_item(OP_MASK_CLEAR, 16'($urandom_range(65535)));
    foreach (pat[i]) if (i < MASK_DEPTH) queue_item(OP_MASK_APPEND, pat[i]);
    foreach (line[i]) if (i < SUBJ_DEPTH) queue_item(OP_SUBJ_APPEND, line[i]);
    if ($urandom_range(7) == 0) queue_item(OP_SUBJ_APPEND, 16'h0000);
    queue_item(OP_RUN, 16'($urandom_range(65535)));
  endtask

  task automatic queue_noise();
    op_t op;
    op = op_t'($urandom_range(3));
    queue_item(op, 16'($urandom));
  endtask

  task automatic drain();
    while (!(pending_items.size() == 0 && n_accepted == n_queued &&
             expected_reports.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int target;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 0;
    n_queued = 0;
    n_accepted = 0;
    n_errors = 0;
    pat_count = 0;
    line_count = 0;
    overrun = 0;
    frm_depth = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty mask and subject, ignored zero characters, extreme codes.
    queue_item(OP_RUN, 16'hFFFF);
    queue_item(OP_MASK_APPEND, 16'h0000);
    queue_item(OP_MASK_APPEND, 16'hFFFF);
    queue_item(OP_SUBJ_APPEND, 16'hFFFF);
    queue_item(OP_RUN, 16'h0000);
    queue_item(OP_MASK_CLEAR, 16'hFFFF);
    queue_item(OP_MASK_APPEND, CH_QMARK);
    queue_item(OP_MASK_APPEND, CH_SPACE);
    queue_item(OP_MASK_APPEND, CH_STAR);
    queue_item(OP_MASK_APPEND, 16'h0033);
    queue_item(OP_SUBJ_APPEND, 16'h8000);
    queue_item(OP_SUBJ_APPEND, CH_TAB);
    queue_item(OP_SUBJ_APPEND, CH_MINUS);
    queue_item(OP_SUBJ_APPEND, 16'h0037);
    queue_item(OP_RUN, 16'h5555);
    // Full stores: the overflow survives a mask clear and is reported on the run.
    for (int i = 0; i <= MASK_DEPTH; i++) queue_item(OP_MASK_APPEND, CH_QMARK);
    queue_item(OP_MASK_CLEAR, 16'h0000);
    queue_item(OP_RUN, 16'h0000);
    for (int i = 0; i <= SUBJ_DEPTH; i++) queue_item(OP_SUBJ_APPEND, 16'h0061);
    queue_item(OP_RUN, 16'h0000);
    // More stars than frames.
    queue_item(OP_MASK_CLEAR, 16'h0000);
    for (int i = 0; i <= FRAME_LIMIT; i++) begin
      queue_item(OP_MASK_APPEND, CH_STAR);
      queue_item(OP_MASK_APPEND, 16'h0078);
    end
    queue_item(OP_MASK_APPEND, 16'h0062);
    queue_item(OP_SUBJ_APPEND, 16'h0062);
    queue_item(OP_RUN, 16'h0000);
    // Repeated token, trailing star and the drive colon sequence.
    queue_item(OP_MASK_CLEAR, 16'h0000);
    queue_item(OP_MASK_APPEND, CH_STAR);
    queue_item(OP_MASK_APPEND, CH_ONE);
    queue_item(OP_MASK_APPEND, 16'h0061);
    queue_item(OP_MASK_APPEND, CH_STAR);
    queue_item(OP_MASK_APPEND, CH_ONE);
    queue_item(OP_MASK_APPEND, CH_COLON);
    queue_item(OP_MASK_APPEND, CH_BSL);
    queue_item(OP_MASK_APPEND, CH_STAR);
    queue_item(OP_MASK_APPEND, CH_TWO);
    queue_item(OP_MASK_APPEND, CH_STAR);
    queue_item(OP_SUBJ_APPEND, 16'h0062);
    queue_item(OP_SUBJ_APPEND, 16'h0061);
    queue_item(OP_SUBJ_APPEND, 16'h0063);
    queue_item(OP_SUBJ_APPEND, CH_COLON);
    queue_item(OP_SUBJ_APPEND, CH_SLASH);
    queue_item(OP_SUBJ_APPEND, 16'h0064);
    queue_item(OP_RUN, 16'h0000);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      target = n_queued + 250;
      if (phase == 0) hold_go = 1;
      while (n_queued < target) begin
        if ($urandom_range(9) == 0) queue_noise();
        else if ($urandom_range(59) == 0) queue_pair(40);
        else queue_pair(4);
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (expected_reports.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
